/* rtl/gld_pkg.sv */
// ----------------------------------------------------------------------------
// gld_pkg
// Shared types, constants and helpers of the GIF LZW frame decoder.
// ----------------------------------------------------------------------------
package gld_pkg;

  // default sizes
  localparam int DICT_ENTRIES_DEF   = 4096;
  localparam int MAX_CODE_WIDTH_DEF = 12;
  localparam int COORD_BITS_DEF     = 16;

  // fixed field widths
  localparam int CODE_BITS     = 12;
  localparam int SLOT_BITS     = 13;
  localparam int BUF_BITS      = 20;
  localparam int HELD_BITS     = 5;
  localparam int OUT_BITS      = 48;
  localparam int POS_BITS      = 17;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // a data byte is refused once more bits than this are held
  localparam logic [HELD_BITS-1:0] HELD_LIMIT = 5'd12;

  // min code size saturation bounds and reset value
  localparam logic [3:0] MCB_MIN = 4'd2;
  localparam logic [3:0] MCB_MAX = 4'd9;
  localparam logic [3:0] MCB_RST = 4'd8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_CODE_BITS = 3'd0,
    REG_FRAME_WIDTH   = 3'd1,
    REG_FRAME_HEIGHT  = 3'd2,
    REG_INTERLACED    = 3'd3,
    REG_OFFSET_X      = 3'd4,
    REG_OFFSET_Y      = 3'd5,
    REG_CANVAS_WIDTH  = 3'd6,
    REG_CANVAS_HEIGHT = 3'd7
  } gld_reg_e;

  // decode phase
  typedef enum logic [1:0] {
    PH_RUN     = 2'd0,
    PH_CLEARED = 2'd1,
    PH_DAMAGED = 2'd2,
    PH_DONE    = 2'd3
  } gld_phase_e;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NEED     = 2'd1;
  localparam logic [1:0] ST_DAMAGED  = 2'd2;
  localparam logic [1:0] ST_FINISHED = 2'd3;

  // row step of each interlace pass
  function automatic logic [3:0] pass_step(input logic [2:0] p);
    case (p)
      3'd0:    pass_step = 4'd1;
      3'd1:    pass_step = 4'd8;
      3'd2:    pass_step = 4'd8;
      3'd3:    pass_step = 4'd4;
      3'd4:    pass_step = 4'd2;
      default: pass_step = 4'd1;
    endcase
  endfunction

  // first row of each interlace pass
  function automatic logic [3:0] pass_start(input logic [2:0] p);
    case (p)
      3'd2:    pass_start = 4'd4;
      3'd3:    pass_start = 4'd2;
      3'd4:    pass_start = 4'd1;
      default: pass_start = 4'd0;
    endcase
  endfunction

  // result packing, lowest field first
  function automatic logic [OUT_BITS-1:0] pack_result(
    input logic                taken,
    input logic                pvalid,
    input logic [7:0]          pidx,
    input logic [POS_BITS-1:0] px,
    input logic [POS_BITS-1:0] py,
    input logic                in_canvas,
    input logic                done,
    input logic [1:0]          status
  );
    pack_result = {status, done, in_canvas, py, px, pidx, pvalid, taken};
  endfunction

endpackage

/* rtl/gld_dict.sv */
// ----------------------------------------------------------------------------
// gld_dict
// LZW dictionary memory: prefix code and suffix byte per slot, registered read.
// ----------------------------------------------------------------------------
module gld_dict
  import gld_pkg::*;
#(
  parameter int DictEntries = DICT_ENTRIES_DEF,
  localparam int AW = $clog2(DictEntries)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [CODE_BITS-1:0] wprefix_i,
  input  logic [7:0]           wsuffix_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [CODE_BITS-1:0] rprefix_o,
  output logic [7:0]           rsuffix_o
);

  logic [CODE_BITS+7:0] mem [DictEntries];
  logic [CODE_BITS+7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wprefix_i, wsuffix_i};
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rprefix_o = rdata_q[CODE_BITS+7:8];
  assign rsuffix_o = rdata_q[7:0];

endmodule

/* rtl/gld_stack.sv */
// ----------------------------------------------------------------------------
// gld_stack
// Expansion stack memory: pixel bytes of a string, popped in reverse order.
// ----------------------------------------------------------------------------
module gld_stack
  import gld_pkg::*;
#(
  parameter int DictEntries = DICT_ENTRIES_DEF,
  localparam int AW = $clog2(DictEntries)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DictEntries];
  logic [7:0] rdata_q;

  // push port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered pop port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gld_place.sv */
// ----------------------------------------------------------------------------
// gld_place
// Pixel placement: frame column/row, interlace pass, canvas position and clip.
// ----------------------------------------------------------------------------
module gld_place
  import gld_pkg::*;
#(
  parameter int CoordBits = COORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 pass_load_i,
  input  logic                 interlaced_i,
  input  logic [CoordBits-1:0] frame_w_i,
  input  logic [CoordBits-1:0] frame_h_i,
  input  logic [CoordBits-1:0] off_x_i,
  input  logic [CoordBits-1:0] off_y_i,
  input  logic [CoordBits-1:0] canvas_w_i,
  input  logic [CoordBits-1:0] canvas_h_i,
  output logic [POS_BITS-1:0]  x_o,
  output logic [POS_BITS-1:0]  y_o,
  output logic                 inside_o,
  output logic                 done_o
);

  logic [CoordBits-1:0] col_q, col_d, row_q, row_d;
  logic [2:0]           pass_q, pass_d;
  logic [CoordBits:0]   x, y, col_nx, row_nx;
  logic [2:0]           p;

  // canvas position and clip flag
  assign x        = {1'b0, off_x_i} + {1'b0, col_q};
  assign y        = {1'b0, off_y_i} + {1'b0, row_q};
  assign x_o      = POS_BITS'(x);
  assign y_o      = POS_BITS'(y);
  assign inside_o = (x < {1'b0, canvas_w_i}) && (y < {1'b0, canvas_h_i});

  // advance column, then row and pass at the end of a row
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pass_d = pass_q;
    done_o = 1'b0;
    col_nx = {1'b0, col_q} + 1'b1;
    p      = (pass_q > 3'd4) ? 3'd0 : pass_q;
    row_nx = {1'b0, row_q} + (CoordBits+1)'(pass_step(p));
    if (col_nx >= {1'b0, frame_w_i}) begin
      for (int i = 0; i < 3; i++) begin
        if (row_nx >= {1'b0, frame_h_i} && p >= 3'd1 && p <= 3'd3) begin
          p      = p + 3'd1;
          row_nx = (CoordBits+1)'(pass_start(p));
        end
      end
      done_o = (row_nx >= {1'b0, frame_h_i});
    end
    if (step_i) begin
      if (col_nx >= {1'b0, frame_w_i}) begin
        col_d  = '0;
        row_d  = row_nx[CoordBits-1:0];
        pass_d = p;
      end else begin
        col_d = col_nx[CoordBits-1:0];
      end
    end
    if (pass_load_i) begin
      pass_d = {2'b00, interlaced_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pass_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pass_q <= pass_d;
    end
  end

endmodule

/* rtl/gif_lzw_frame_decoder.sv */
// ----------------------------------------------------------------------------
// gif_lzw_frame_decoder
// GIF LZW image data decoder: sub-block bytes in, placed palette pixels out.
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  s_axis    | in        | tuser: command, tdata: data_byte
//  m_axis    | out       | tdata: one result per input transaction
//  cfg       | in        | write enable, register index, write data
//
//  A byte transaction's result is registered in the cycle after acceptance.
//  A pixel request pops the stack when a string is pending: S_CODE issues the pop read, S_PIX places the byte.
//  Otherwise the next code is unpacked, and each prefix chain entry takes a
//  dictionary read (S_WALK) then a stack push (S_RD), so a new string is
//  expanded onto the stack before its first pixel comes out.
//  Reset is asynchronous; no clearing pass, memories are valid when written.
//  The output register holds a result until m_axis_tready; input waits then.
// ----------------------------------------------------------------------------
module gif_lzw_frame_decoder
  import gld_pkg::*;
#(
  parameter int DictEntries  = DICT_ENTRIES_DEF,
  parameter int MaxCodeWidth = MAX_CODE_WIDTH_DEF,
  parameter int CoordBits    = COORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,  // [7:0] data_byte
  input  logic                     s_axis_tuser,  // [0] command
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [0] byte_taken, [1] pixel_valid, [9:2] pixel_index, [26:10] pixel_x,
  // [43:27] pixel_y, [44] inside_canvas, [45] frame_done, [47:46] status
  output logic [OUT_BITS-1:0]      m_axis_tdata,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int AW = $clog2(DictEntries);
  localparam int LW = AW + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CODE = 5'b00010,
    S_WALK = 5'b00100,
    S_RD   = 5'b01000,
    S_PIX  = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  gld_phase_e            phase_q, phase_d;
  logic [3:0]            mcb_q, mcb_d, cw_q, cw_d, mcb_sat;
  logic [CoordBits-1:0]  fw_q, fh_q, ox_q, oy_q, cnw_q, cnh_q;
  logic                  ilace_q;
  logic [BUF_BITS-1:0]   buf_q, buf_d;
  logic [HELD_BITS-1:0]  held_q, held_d;
  logic [7:0]            blk_q, blk_d;
  logic [SLOT_BITS-1:0]  nslot_q, nslot_d, nslot_n;
  logic [CODE_BITS-1:0]  old_q, old_d, cur_q, cur_d, c_q, c_d, code, cc;
  logic [7:0]            first_q, first_d;
  logic [LW-1:0]         level_q, level_d;
  logic                  oob_q, oob_d;
  logic                  out_valid_q;
  logic [OUT_BITS-1:0]   out_q, out_d;
  logic                  out_load;

  logic [SLOT_BITS-1:0]  clr, end_code, first_new, limit;
  logic [BUF_BITS-1:0]   code_mask;
  logic                  level_full, accept, cmd;

  logic                  dict_we;
  logic [AW-1:0]         dict_wa, dict_ra;
  logic [CODE_BITS-1:0]  dict_rprefix;
  logic [7:0]            dict_rsuffix;
  logic                  stk_we;
  logic [AW-1:0]         stk_wa, stk_ra;
  logic [7:0]            stk_wd, stk_rd;

  logic                  place_step, pass_load;
  logic [POS_BITS-1:0]   pix_x, pix_y;
  logic                  pix_inside, pix_done;

  gld_dict #(.DictEntries(DictEntries)) u_dict (
    .clk_i     (clk_i),
    .we_i      (dict_we),
    .waddr_i   (dict_wa),
    .wprefix_i (old_q),
    .wsuffix_i (cur_q[7:0]),
    .raddr_i   (dict_ra),
    .rprefix_o (dict_rprefix),
    .rsuffix_o (dict_rsuffix)
  );

  gld_stack #(.DictEntries(DictEntries)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_wa),
    .wdata_i (stk_wd),
    .raddr_i (stk_ra),
    .rdata_o (stk_rd)
  );

  gld_place #(.CoordBits(CoordBits)) u_place (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (place_step),
    .pass_load_i  (pass_load),
    .interlaced_i (cfg_data_i[0]),
    .frame_w_i    (fw_q),
    .frame_h_i    (fh_q),
    .off_x_i      (ox_q),
    .off_y_i      (oy_q),
    .canvas_w_i   (cnw_q),
    .canvas_h_i   (cnh_q),
    .x_o          (pix_x),
    .y_o          (pix_y),
    .inside_o     (pix_inside),
    .done_o       (pix_done)
  );

  // handshake
  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = s_axis_tuser;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // code values derived from the current sizes
  assign clr        = SLOT_BITS'(1) << mcb_q;
  assign end_code   = clr + 1'b1;
  assign first_new  = clr + 2'd2;
  assign limit      = SLOT_BITS'(1) << cw_q;
  assign code_mask  = ~({BUF_BITS{1'b1}} << cw_q);
  assign code       = CODE_BITS'(buf_q & code_mask);
  assign level_full = (level_q >= LW'(DictEntries));
  assign pass_load  = cfg_we_i && (cfg_idx_i == REG_INTERLACED);

  // saturated min code size from a config write
  always_comb begin
    mcb_sat = cfg_data_i[3:0];
    if (mcb_sat < MCB_MIN) mcb_sat = MCB_MIN;
    if (mcb_sat > MCB_MAX) mcb_sat = MCB_MAX;
  end

  // decoder sequencer
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    mcb_d      = mcb_q;
    cw_d       = cw_q;
    buf_d      = buf_q;
    held_d     = held_q;
    blk_d      = blk_q;
    nslot_d    = nslot_q;
    nslot_n    = nslot_q;
    old_d      = old_q;
    cur_d      = cur_q;
    c_d        = c_q;
    first_d    = first_q;
    level_d    = level_q;
    oob_d      = oob_q;
    out_load   = 1'b0;
    out_d      = '0;
    dict_we    = 1'b0;
    dict_wa    = nslot_q[AW-1:0];
    dict_ra    = cur_q[AW-1:0];
    stk_we     = 1'b0;
    stk_wa     = level_q[AW-1:0];
    stk_wd     = cur_q[7:0];
    stk_ra     = AW'(level_q - 1'b1);
    place_step = 1'b0;
    cc         = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (phase_q == PH_DAMAGED || phase_q == PH_DONE) begin
            out_load = 1'b1;
            out_d    = pack_result(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0, phase_q);
          end else if (!cmd) begin
            out_load = 1'b1;
            out_d    = pack_result(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0, ST_OK);
            if (blk_q == '0) begin
              if (s_axis_tdata != '0) begin
                blk_d    = s_axis_tdata;
                out_d[0] = 1'b1;
              end else if (level_q == '0 && held_q < {1'b0, cw_q}) begin
                phase_d = PH_DAMAGED;
                out_d   = pack_result(1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b0, ST_DAMAGED);
              end
            end else if (held_q <= HELD_LIMIT) begin
              buf_d    = buf_q | (BUF_BITS'(s_axis_tdata) << held_q);
              held_d   = held_q + 5'd8;
              blk_d    = blk_q - 1'b1;
              out_d[0] = 1'b1;
            end
          end else begin
            state_d = S_CODE;
          end
        end
      end

      // pop a pending pixel or unpack the next code
      S_CODE: begin
        if (level_q != '0) begin
          level_d = level_q - 1'b1;
          state_d = S_PIX;
        end else if (held_q < {1'b0, cw_q}) begin
          out_load = 1'b1;
          out_d    = pack_result(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0, ST_NEED);
          state_d  = S_IDLE;
        end else begin
          buf_d  = buf_q >> cw_q;
          held_d = held_q - {1'b0, cw_q};
          if ({1'b0, code} == end_code) begin
            phase_d  = PH_DONE;
            out_load = 1'b1;
            out_d    = pack_result(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0, ST_FINISHED);
            state_d  = S_IDLE;
          end else if ({1'b0, code} == clr) begin
            cw_d    = mcb_q + 1'b1;
            nslot_d = first_new;
            phase_d = PH_CLEARED;
          end else if (phase_q == PH_CLEARED) begin
            cc      = ({1'b0, code} >= nslot_q) ? '0 : code;
            old_d   = cc;
            first_d = cc[7:0];
            stk_we  = 1'b1;
            stk_wa  = '0;
            stk_wd  = cc[7:0];
            level_d = LW'(1);
            phase_d = PH_RUN;
          end else begin
            c_d = code;
            if ({1'b0, code} >= nslot_q) begin
              // string plus its own first byte
              cur_d   = old_q;
              stk_we  = 1'b1;
              stk_wa  = '0;
              stk_wd  = first_q;
              level_d = LW'(1);
            end else begin
              cur_d = code;
            end
            state_d = S_WALK;
          end
        end
      end

      // follow the prefix chain or finish the string
      S_WALK: begin
        if ({1'b0, cur_q} >= first_new) begin
          dict_ra = cur_q[AW-1:0];
          oob_d   = ({1'b0, cur_q} >= SLOT_BITS'(DictEntries));
          state_d = S_RD;
        end else if (level_full) begin
          phase_d  = PH_DAMAGED;
          out_load = 1'b1;
          out_d    = pack_result(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0, ST_DAMAGED);
          state_d  = S_IDLE;
        end else begin
          stk_we  = 1'b1;
          stk_wd  = cur_q[7:0];
          level_d = level_q + 1'b1;
          if (nslot_q < limit && nslot_q < SLOT_BITS'(DictEntries)) begin
            dict_we = 1'b1;
            nslot_n = nslot_q + 1'b1;
          end
          nslot_d = nslot_n;
          first_d = cur_q[7:0];
          old_d   = c_q;
          if (nslot_n >= limit && cw_q < 4'(MaxCodeWidth)) begin
            cw_d = cw_q + 1'b1;
          end
          state_d = S_CODE;
        end
      end

      // dictionary entry arrived: push suffix, go to prefix
      S_RD: begin
        if (level_full) begin
          phase_d  = PH_DAMAGED;
          out_load = 1'b1;
          out_d    = pack_result(1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0, ST_DAMAGED);
          state_d  = S_IDLE;
        end else begin
          stk_we  = 1'b1;
          stk_wd  = oob_q ? 8'd0 : dict_rsuffix;
          level_d = level_q + 1'b1;
          cur_d   = oob_q ? '0 : dict_rprefix;
          state_d = S_WALK;
        end
      end

      // popped byte arrived: place it
      S_PIX: begin
        place_step = 1'b1;
        out_load   = 1'b1;
        out_d      = pack_result(1'b0, 1'b1, stk_rd, pix_x, pix_y, pix_inside, pix_done,
                                 pix_done ? ST_FINISHED : ST_OK);
        if (pix_done) phase_d = PH_DONE;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    // configuration writes that reload decoder state
    if (cfg_we_i && cfg_idx_i == REG_MIN_CODE_BITS) begin
      mcb_d   = mcb_sat;
      cw_d    = mcb_sat + 1'b1;
      nslot_d = (SLOT_BITS'(1) << mcb_sat) + 2'd2;
    end
  end

  // control and decoder registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_RUN;
      mcb_q       <= MCB_RST;
      cw_q        <= MCB_RST + 1'b1;
      buf_q       <= '0;
      held_q      <= '0;
      blk_q       <= '0;
      nslot_q     <= (SLOT_BITS'(1) << MCB_RST) + 2'd2;
      old_q       <= '0;
      first_q     <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
      fw_q        <= '0;
      fh_q        <= '0;
      ox_q        <= '0;
      oy_q        <= '0;
      cnw_q       <= '0;
      cnh_q       <= '0;
      ilace_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      mcb_q   <= mcb_d;
      cw_q    <= cw_d;
      buf_q   <= buf_d;
      held_q  <= held_d;
      blk_q   <= blk_d;
      nslot_q <= nslot_d;
      old_q   <= old_d;
      first_q <= first_d;
      level_q <= level_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      // geometry registers
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FRAME_WIDTH:   fw_q    <= cfg_data_i[CoordBits-1:0];
          REG_FRAME_HEIGHT:  fh_q    <= cfg_data_i[CoordBits-1:0];
          REG_INTERLACED:    ilace_q <= cfg_data_i[0];
          REG_OFFSET_X:      ox_q    <= cfg_data_i[CoordBits-1:0];
          REG_OFFSET_Y:      oy_q    <= cfg_data_i[CoordBits-1:0];
          REG_CANVAS_WIDTH:  cnw_q   <= cfg_data_i[CoordBits-1:0];
          REG_CANVAS_HEIGHT: cnh_q   <= cfg_data_i[CoordBits-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    c_q   <= c_d;
    oob_q <= oob_d;
    if (out_load) out_q <= out_d;
  end

  // stack never written past its depth
  a_push_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_we |-> !level_full)
    else $error("stack push beyond depth");

  // input taken only while the sequencer is idle
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == S_IDLE)
    else $error("input ready outside idle");

  // placement always follows a pop read issued in the previous cycle
  a_pix_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PIX |-> $past(state_q) == S_CODE && $past(level_q) != '0)
    else $error("pixel state without pop");

  // an interlaced flag write keeps the stored flag
  a_ilace_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_load |=> ilace_q == $past(cfg_data_i[0]))
    else $error("interlace flag not stored");

endmodule
